@@ design/nearest_point_search_core_macros.svh @@
// Assertion macros for the checker file of the nearest point search core.
// Included by bare file name; depends on nothing else.
`ifndef NEAREST_POINT_SEARCH_CORE_MACROS_SVH
`define NEAREST_POINT_SEARCH_CORE_MACROS_SVH

// Concurrent assertion clocked on the rising edge, quiet while reset is low.
`define NPS_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("nearest point search assertion failed");

// Same-cycle implication built on the macro above.
`define NPS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  `NPS_ASSERT(label, clk, rstn, (ante) |-> (cons))

// Next-cycle implication built on the first macro.
`define NPS_ASSERT_NXT(label, clk, rstn, ante, cons) \
  `NPS_ASSERT(label, clk, rstn, (ante) |=> (cons))

`endif

@@ design/nps_pkg.sv @@
// Package of the nearest point search core: field widths, codes, types.
// Used by the channel interfaces and the core; depends on nothing.
`default_nettype none

package nps_pkg;

  localparam int FieldW         = 24;
  localparam int NearIndexW     = 7;
  localparam int MaxPointsDef   = 128;
  localparam int SqW            = 2 * FieldW;
  localparam int DistW          = SqW + 1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic signed [FieldW-1:0] field_t;

  // One stored trajectory point.
  typedef struct packed {
    field_t x;
    field_t y;
    field_t heading;
    field_t speed;
    field_t steer;
    field_t curv;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_RESULT
  } state_e;

endpackage

`default_nettype wire

@@ design/nps_in_if.sv @@
// Input channel of the nearest point search core: valid/ready plus one item.
// Depends on nps_pkg for the field type.
`default_nettype none

interface nps_in_if import nps_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   func;
  logic   restart;
  field_t pos_x;
  field_t pos_y;
  field_t heading;
  field_t speed;
  field_t steer;
  field_t curv;

  modport source (output valid, func, restart, pos_x, pos_y, heading, speed, steer, curv,
                  input ready);
  modport sink   (input valid, func, restart, pos_x, pos_y, heading, speed, steer, curv,
                  output ready);
endinterface

`default_nettype wire

@@ design/nps_out_if.sv @@
// Result channel of the nearest point search core: valid/ready plus one result.
// Depends on nps_pkg for widths and the field type.
`default_nettype none

interface nps_out_if import nps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [NearIndexW-1:0] near_index;
  field_t                near_x;
  field_t                near_y;
  field_t                near_heading;
  field_t                near_speed;
  field_t                near_steer;
  field_t                near_curv;

  modport source (output valid, found, near_index, near_x, near_y, near_heading,
                  near_speed, near_steer, near_curv,
                  input ready);
  modport sink   (input valid, found, near_index, near_x, near_y, near_heading,
                  near_speed, near_steer, near_curv,
                  output ready);
endinterface

`default_nettype wire

@@ design/nearest_point_search_core.sv @@
// Nearest point search core: point table in one synchronous memory, linear scan.
// Depends on nps_pkg, nps_in_if and nps_out_if.
//
//   channel | dir | transaction
//   in_i    | in  | load (func=0) stores a point, query (func=1) carries a pose
//   out_o   | out | one result per query: found flag, index and point fields
//
// A load is handled in idle and dropped when the table is full without restart.
// A query on N stored points takes one memory read per cycle, then a two-stage
// square/compare pipeline and one more read of the winning entry; its result is
// registered once the output register is free. An empty-table query skips the scan.
// Reset clears the point count, the state and the valid flags; the table is not cleared.
// The input is accepted only in idle; a finished result waits in the output
// register while loads and the next scan proceed.
`default_nettype none

module nearest_point_search_core import nps_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  nps_in_if.sink    in_i,
  nps_out_if.source out_o
);

  localparam int IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CntW = $clog2(MAX_POINTS + 1);

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] scan_idx_q, scan_idx_d;
  logic            found_q, found_d;
  field_t          qx_q, qy_q;

  point_t          point_mem [MAX_POINTS];
  point_t          rd_data_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  point_t          wr_data;

  logic            scan_last;
  logic            s1_valid_q, s1_last_q;
  logic [IdxW-1:0] s1_idx_q;
  logic            s2_valid_q, s2_last_q;
  logic [IdxW-1:0] s2_idx_q;
  logic [SqW-1:0]  sq_x_q, sq_y_q;

  logic signed [FieldW:0] dx, dy;
  logic [FieldW-1:0]      abs_dx, abs_dy;
  logic [DistW-1:0]       sq_dist;
  logic [DistW-1:0]       best_dist_q;
  logic [IdxW-1:0]        best_idx_q;

  logic            in_accept;
  logic            out_load;
  logic            out_valid_q;
  logic            out_found_q;
  logic [IdxW-1:0] out_idx_q;
  point_t          out_point_q;

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign scan_last = (scan_idx_q == IdxW'(count_q - CntW'(1)));
  assign wr_data = '{x: in_i.pos_x, y: in_i.pos_y, heading: in_i.heading,
                     speed: in_i.speed, steer: in_i.steer, curv: in_i.curv};

  // Writes happen only in idle and reads only while scanning or fetching,
  // so the memory never sees a read and a write of the same entry at once.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    found_d    = found_q;
    rd_en      = 1'b0;
    rd_addr    = scan_idx_q;
    wr_en      = 1'b0;
    wr_addr    = '0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_i.func == FUNC_LOAD) begin
            if (in_i.restart) begin
              wr_en   = 1'b1;
              wr_addr = '0;
              count_d = CntW'(1);
            end else if (count_q < CntW'(MAX_POINTS)) begin
              wr_en   = 1'b1;
              wr_addr = IdxW'(count_q);
              count_d = count_q + CntW'(1);
            end
          end else if (count_q == '0) begin
            found_d = 1'b0;
            state_d = ST_RESULT;
          end else begin
            found_d    = 1'b1;
            scan_idx_d = '0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_last) begin
          state_d = ST_DRAIN;
        end else begin
          scan_idx_d = scan_idx_q + IdxW'(1);
        end
      end
      ST_DRAIN: begin
        if (s2_valid_q && s2_last_q) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = best_idx_q;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      s1_valid_q <= (state_q == ST_SCAN);
      s2_valid_q <= s1_valid_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      point_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= point_mem[rd_addr];
    end
  end

  // First stage: distance components of the entry read last cycle; second stage: the sum of their squares.
  always_comb begin
    dx      = {rd_data_q.x[FieldW-1], rd_data_q.x} - {qx_q[FieldW-1], qx_q};
    dy      = {rd_data_q.y[FieldW-1], rd_data_q.y} - {qy_q[FieldW-1], qy_q};
    abs_dx  = dx[FieldW] ? FieldW'(-dx) : FieldW'(dx);
    abs_dy  = dy[FieldW] ? FieldW'(-dy) : FieldW'(dy);
    sq_dist = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    found_q    <= found_d;
    if (in_accept && in_i.func == FUNC_QUERY) begin
      qx_q <= in_i.pos_x;
      qy_q <= in_i.pos_y;
    end
    s1_idx_q  <= scan_idx_q;
    s1_last_q <= scan_last;
    s2_idx_q  <= s1_idx_q;
    s2_last_q <= s1_last_q;
    sq_x_q    <= abs_dx * abs_dx;
    sq_y_q    <= abs_dy * abs_dy;
    // Strict compare keeps the lowest index on equal distances.
    if (s2_valid_q && (s2_idx_q == '0 || sq_dist < best_dist_q)) begin
      best_dist_q <= sq_dist;
      best_idx_q  <= s2_idx_q;
    end
    if (out_load) begin
      out_found_q <= found_q;
      out_idx_q   <= found_q ? best_idx_q : '0;
      out_point_q <= found_q ? rd_data_q : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = out_found_q;
  assign out_o.near_index   = NearIndexW'(out_idx_q);
  assign out_o.near_x       = out_point_q.x;
  assign out_o.near_y       = out_point_q.y;
  assign out_o.near_heading = out_point_q.heading;
  assign out_o.near_speed   = out_point_q.speed;
  assign out_o.near_steer   = out_point_q.steer;
  assign out_o.near_curv    = out_point_q.curv;

endmodule

`default_nettype wire

@@ design/nps_checker.sv @@
// Port-level checker for the nearest point search core, bound into the core module.
// Depends on nps_pkg and the assertion macros header.
`default_nettype none

`include "nearest_point_search_core_macros.svh"

module nps_checker import nps_pkg::*; (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_valid_i,
  input wire                  in_ready_i,
  input wire                  in_func_i,
  input wire                  out_valid_i,
  input wire                  out_ready_i,
  input wire                  out_found_i,
  input wire [NearIndexW-1:0] out_near_index_i,
  input wire [FieldW-1:0]     out_near_x_i,
  input wire [FieldW-1:0]     out_near_curv_i
);

  // A pending result stays offered until it is taken.
  `NPS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A query keeps the block busy for at least the cycle after it is accepted.
  `NPS_ASSERT_NXT(a_query_busy, clk_i, rst_ni, in_valid_i && in_ready_i && in_func_i == FUNC_QUERY, !in_ready_i)

  // An empty-table result carries zero index and zero x and curv fields.
  `NPS_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, out_valid_i && !out_found_i, out_near_index_i == '0 && out_near_x_i == '0 && out_near_curv_i == '0)

endmodule

bind nearest_point_search_core nps_checker u_nps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_func_i       (in_i.func),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_found_i     (out_o.found),
  .out_near_index_i(out_o.near_index),
  .out_near_x_i    (out_o.near_x),
  .out_near_curv_i (out_o.near_curv)
);

`default_nettype wire

@@ verif/tb_nearest_point_search_core.sv @@
// Testbench of nearest_point_search_core: directed table, then random load/query runs,
// each result checked against a stated value or a behavioral nearest-point predictor in this file.
// Depends on nps_pkg, nps_in_if, nps_out_if and the core itself.
module tb_nearest_point_search_core;
  import nps_pkg::*;

  localparam int MaxPts     = MaxPointsDef;
  localparam int HoldLen    = 400;
  localparam int CycleLimit = 1000000;
  localparam int NumRows    = 20;
  localparam int RandItems  = 530;
  localparam field_t FMax   = 24'sh7FFFFF;
  localparam field_t FMin   = 24'sh800000;
  localparam field_t One    = 24'sh001000;

  typedef struct packed {
    logic   func;
    logic   restart;
    point_t pt;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [NearIndexW-1:0] idx;
    point_t                pt;
  } near_t;

  typedef struct {
    req_t  rq;
    bit    typed;
    near_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  nps_in_if  in_ch ();
  nps_out_if out_ch ();

  nearest_point_search_core #(.MAX_POINTS(MaxPts)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: the stored trajectory and its length.
  point_t traj_pts [MaxPts];
  int     traj_count;
  near_t  pending_nearest [$];

  int     snd_idle_pct;
  int     rcv_stall_pct;
  int     hold_reqs;
  int     hold_served;
  int     hold_left;
  int     items_sent;
  int     errors;
  int     cycles;
  near_t  got;
  near_t  exp_res;
  row_t   steps [NumRows];

  function automatic req_t mk(logic func, logic restart, field_t x, field_t y,
                              field_t h, field_t s, field_t st, field_t c);
    req_t r;
    r.func       = func;
    r.restart    = restart;
    r.pt.x       = x;
    r.pt.y       = y;
    r.pt.heading = h;
    r.pt.speed   = s;
    r.pt.steer   = st;
    r.pt.curv    = c;
    return r;
  endfunction

  function automatic near_t hit(int idx, req_t src);
    near_t n;
    n.found = 1'b1;
    n.idx   = idx[NearIndexW-1:0];
    n.pt    = src.pt;
    return n;
  endfunction

  function automatic field_t rnd_field();
    return field_t'($urandom());
  endfunction

  function automatic field_t offset(field_t base, int span);
    return field_t'(int'(base) + $urandom_range(0, 2 * span) - span);
  endfunction

  task automatic store_point(input req_t rq);
    if (rq.restart) traj_count = 0;
    if (traj_count < MaxPts) begin
      traj_pts[traj_count] = rq.pt;
      traj_count++;
    end
  endtask

  // Linear scan for the least squared distance; the lowest index wins a tie.
  function automatic near_t nearest_point(field_t qx, field_t qy);
    near_t  res;
    longint dx;
    longint dy;
    longint sum_sq;
    longint best_dist;
    int     best;
    res       = '0;
    best      = 0;
    best_dist = 0;
    if (traj_count == 0) return res;
    for (int i = 0; i < traj_count; i++) begin
      dx     = longint'(traj_pts[i].x) - longint'(qx);
      dy     = longint'(traj_pts[i].y) - longint'(qy);
      sum_sq = dx * dx + dy * dy;
      if (i == 0 || sum_sq < best_dist) begin
        best_dist = sum_sq;
        best      = i;
      end
    end
    res.found = 1'b1;
    res.idx   = best[NearIndexW-1:0];
    res.pt    = traj_pts[best];
    return res;
  endfunction

  // Offers one item, waits for its transaction and updates the prediction.
  task automatic send_item(input req_t rq, input bit typed, input near_t want);
    near_t want_res;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= rq.func;
    in_ch.restart <= rq.restart;
    in_ch.pos_x   <= rq.pt.x;
    in_ch.pos_y   <= rq.pt.y;
    in_ch.heading <= rq.pt.heading;
    in_ch.speed   <= rq.pt.speed;
    in_ch.steer   <= rq.pt.steer;
    in_ch.curv    <= rq.pt.curv;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    if (rq.func == FUNC_LOAD) begin
      store_point(rq);
    end else begin
      want_res        = typed ? want : nearest_point(rq.pt.x, rq.pt.y);
      pending_nearest = {pending_nearest, want_res};
    end
  endtask

  task automatic send_query();
    field_t qx;
    field_t qy;
    int     pick;
    int     mode;
    pick = (traj_count > 0) ? $urandom_range(0, traj_count - 1) : 0;
    mode = $urandom_range(0, 3);
    if (mode == 0 || traj_count == 0) begin
      qx = rnd_field();
      qy = rnd_field();
    end else if (mode == 1) begin
      qx = traj_pts[pick].x;
      qy = traj_pts[pick].y;
    end else begin
      qx = offset(traj_pts[pick].x, 64);
      qy = offset(traj_pts[pick].y, 64);
    end
    // Restart and the load-only fields carry noise; a query ignores them.
    send_item(mk(FUNC_QUERY, 1'($urandom()), qx, qy, rnd_field(), rnd_field(),
                 rnd_field(), rnd_field()), 1'b0, '0);
  endtask

  // One trajectory: a first load that mostly restarts, more loads with queries mixed in, then queries.
  task automatic run_trajectory(input bit fill);
    int     n_pts;
    int     n_q;
    int     mode;
    field_t cx;
    field_t cy;
    field_t px;
    field_t py;
    logic   rs;
    n_pts = fill ? MaxPts + $urandom_range(1, 4) : $urandom_range(1, 24);
    n_q   = $urandom_range(1, 6);
    mode  = $urandom_range(0, 2);
    cx    = rnd_field();
    cy    = rnd_field();
    for (int i = 0; i < n_pts; i++) begin
      case (mode)
        0: begin
          px = rnd_field();
          py = rnd_field();
        end
        1: begin
          px = offset(cx, 2048);
          py = offset(cy, 2048);
        end
        default: begin
          // Coarse grid, so equal distances come up often.
          px = field_t'(int'(cx) + ($urandom_range(0, 6) - 3) * int'(One));
          py = field_t'(int'(cy) + ($urandom_range(0, 6) - 3) * int'(One));
        end
      endcase
      // Now and then the first load does not restart and the run appends.
      if (i == 0) rs = ($urandom_range(0, 7) != 0);
      else rs = ($urandom_range(0, 49) == 0);
      send_item(mk(FUNC_LOAD, rs, px, py, rnd_field(), rnd_field(), rnd_field(),
                   rnd_field()), 1'b0, '0);
      if ($urandom_range(0, 5) == 0) send_query();
    end
    for (int i = 0; i < n_q; i++) send_query();
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      out_ch.ready <= 1'b0;
      hold_served  <= hold_reqs;
      hold_left    <= HoldLen;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.found        = out_ch.found;
      got.idx          = out_ch.near_index;
      got.pt.x         = out_ch.near_x;
      got.pt.y         = out_ch.near_y;
      got.pt.heading   = out_ch.near_heading;
      got.pt.speed     = out_ch.near_speed;
      got.pt.steer     = out_ch.near_steer;
      got.pt.curv      = out_ch.near_curv;
      if (pending_nearest.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction, index %0d", got.idx);
      end else begin
        exp_res = pending_nearest[0];
        pending_nearest.delete(0);
        if (got !== exp_res) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp: found %b idx %0d x %h y %h hd %h sp %h st %h cv %h",
                     exp_res.found, exp_res.idx, exp_res.pt.x, exp_res.pt.y,
                     exp_res.pt.heading, exp_res.pt.speed, exp_res.pt.steer,
                     exp_res.pt.curv);
            $display("         got: found %b idx %0d x %h y %h hd %h sp %h st %h cv %h",
                     got.found, got.idx, got.pt.x, got.pt.y, got.pt.heading,
                     got.pt.speed, got.pt.steer, got.pt.curv);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int snd_phase [4];
    int rcv_phase [4];
    int phase_end;
    snd_phase     = '{0, 85, 0, 15};
    rcv_phase     = '{0, 0, 85, 15};
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_LOAD;
    in_ch.restart = 1'b0;
    in_ch.pos_x   = '0;
    in_ch.pos_y   = '0;
    in_ch.heading = '0;
    in_ch.speed   = '0;
    in_ch.steer   = '0;
    in_ch.curv    = '0;
    out_ch.ready  = 1'b0;
    traj_count    = 0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_reqs     = 0;
    hold_served   = 0;
    hold_left     = 0;
    items_sent    = 0;
    errors        = 0;
    cycles        = 0;

    steps = '{
      // Query on an empty table after reset.
      '{mk(FUNC_QUERY, 1'b0, 0, 0, 0, 0, 0, 0), 1'b1, '0},
      '{mk(FUNC_LOAD, 1'b1, FMax, FMin, FMin, FMax, 0, -1), 1'b0, '0},
      '{mk(FUNC_QUERY, 1'b0, FMax, FMin, 0, 0, 0, 0), 1'b1,
        hit(0, mk(FUNC_LOAD, 1'b1, FMax, FMin, FMin, FMax, 0, -1))},
      '{mk(FUNC_LOAD, 1'b0, FMin, FMax, FMax, FMin, -1, 0), 1'b0, '0},
      '{mk(FUNC_QUERY, 1'b0, FMin, FMax, 0, 0, 0, 0), 1'b1,
        hit(1, mk(FUNC_LOAD, 1'b0, FMin, FMax, FMax, FMin, -1, 0))},
      // Largest possible distance along one axis, equal for both points.
      '{mk(FUNC_QUERY, 1'b0, FMax, FMax, 0, 0, 0, 0), 1'b0, '0},
      '{mk(FUNC_LOAD, 1'b0, 0, 0, 5, 6, 7, 8), 1'b0, '0},
      '{mk(FUNC_LOAD, 1'b0, 0, 0, 9, 10, 11, 12), 1'b0, '0},
      '{mk(FUNC_QUERY, 1'b0, 1, -1, 0, 0, 0, 0), 1'b0, '0},
      // Restart and load-only fields on a query must leave the table alone.
      '{mk(FUNC_QUERY, 1'b1, FMin, FMin, FMax, FMin, FMax, FMin), 1'b0, '0},
      '{mk(FUNC_LOAD, 1'b1, One, 0, 1, 2, 3, 4), 1'b0, '0},
      '{mk(FUNC_LOAD, 1'b0, -One, 0, -1, -2, -3, -4), 1'b0, '0},
      '{mk(FUNC_LOAD, 1'b0, 0, One, FMin, FMin, FMin, FMin), 1'b0, '0},
      '{mk(FUNC_QUERY, 1'b0, 0, 0, 0, 0, 0, 0), 1'b0, '0},
      '{mk(FUNC_QUERY, 1'b0, -4095, 0, 0, 0, 0, 0), 1'b0, '0},
      '{mk(FUNC_QUERY, 1'b0, 1, 4000, 0, 0, 0, 0), 1'b0, '0},
      '{mk(FUNC_LOAD, 1'b0, 100, 100, FMax, FMax, FMin, FMin), 1'b0, '0},
      '{mk(FUNC_QUERY, 1'b1, 100, 100, -1, -1, -1, -1), 1'b0, '0},
      '{mk(FUNC_LOAD, 1'b1, -1, -1, 0, 0, 0, 0), 1'b0, '0},
      '{mk(FUNC_QUERY, 1'b0, FMin, FMin, 0, 0, 0, 0), 1'b1,
        hit(0, mk(FUNC_LOAD, 1'b1, -1, -1, 0, 0, 0, 0))}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[i]) send_item(steps[i].rq, steps[i].typed, steps[i].want);

    phase_end = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      snd_idle_pct  = snd_phase[ph];
      rcv_stall_pct = rcv_phase[ph];
      phase_end     = phase_end + RandItems / 4;
      // Long receiver hold-off while items keep coming, so the core backs up.
      if (ph == 0) hold_reqs <= hold_reqs + 1;
      run_trajectory(ph == 1);
      while (items_sent < phase_end) run_trajectory($urandom_range(0, 39) == 0);
    end
    in_ch.valid   <= 1'b0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;

    while (pending_nearest.size() != 0) @(posedge clk_i);
    repeat (MaxPts + 10) @(posedge clk_i);
    if (pending_nearest.size() != 0) begin
      errors += pending_nearest.size();
      $display("%0d expected results never arrived", pending_nearest.size());
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
